[design/psev_pkg.sv]
// ----------------------------------------------------------------------------
// psev_pkg: shared definitions for the postfix stack evaluator
// Token codes, sequencer states and word constants used by every file.
// ----------------------------------------------------------------------------
package psev_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CMD_W = 3;
  localparam int unsigned DEPTH_W = 7;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_PUSH = 3'd0;
  localparam cmd_t CMD_ADD = 3'd1;
  localparam cmd_t CMD_SUB = 3'd2;
  localparam cmd_t CMD_MUL = 3'd3;
  localparam cmd_t CMD_DIV = 3'd4;

  // Value returned by a pop from an empty stack.
  localparam word_t EMPTY_POP_VALUE = 32'hFFFF_FFFF;

  // One quotient bit is produced per divider step.
  localparam int unsigned DIV_STEPS = WORD_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OPER,
    ST_DIV,
    ST_FINISH
  } state_t;

endpackage

[design/psev_stack_ram.sv]
// ----------------------------------------------------------------------------
// psev_stack_ram: stack storage
// Single write port and single read port; read data is registered.
// ----------------------------------------------------------------------------
module psev_stack_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  psev_pkg::word_t wdata,
  input  logic [AW-1:0]   raddr,
  output psev_pkg::word_t rdata
);

  psev_pkg::word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[design/psev_divider.sv]
// ----------------------------------------------------------------------------
// psev_divider: iterative signed divider
// Restoring radix-2 division of magnitudes, one quotient bit per cycle,
// with the sign applied at the output. Truncates toward zero.
// ----------------------------------------------------------------------------
module psev_divider (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  psev_pkg::word_t dividend,
  input  psev_pkg::word_t divisor,
  output logic            done,
  output psev_pkg::word_t quotient
);

  logic                            running;
  logic [psev_pkg::DIV_CNT_W-1:0]  count;
  psev_pkg::word_t                 rem;
  psev_pkg::word_t                 quo;
  psev_pkg::word_t                 dvs;
  logic                            neg;
  logic [psev_pkg::WORD_W:0]       shifted;
  logic [psev_pkg::WORD_W:0]       diff;

  assign shifted = {rem, quo[psev_pkg::WORD_W-1]};
  assign diff = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count <= psev_pkg::DIV_CNT_W'(psev_pkg::DIV_STEPS - 1);
      end else if (running) begin
        count <= count - 1'b1;
        if (count == '0) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend[psev_pkg::WORD_W-1] ? (~dividend + 1'b1) : dividend;
      dvs <= divisor[psev_pkg::WORD_W-1] ? (~divisor + 1'b1) : divisor;
      neg <= dividend[psev_pkg::WORD_W-1] ^ divisor[psev_pkg::WORD_W-1];
    end else if (running) begin
      if (!diff[psev_pkg::WORD_W]) begin
        rem <= diff[psev_pkg::WORD_W-1:0];
        quo <= {quo[psev_pkg::WORD_W-2:0], 1'b1};
      end else begin
        rem <= shifted[psev_pkg::WORD_W-1:0];
        quo <= {quo[psev_pkg::WORD_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? (~quo + 1'b1) : quo;

endmodule

[design/postfix_stack_evaluator_unit.sv]
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_unit: postfix expression evaluator
// Takes one token per word and keeps a bounded stack of 32-bit values.
// ----------------------------------------------------------------------------
// A token word is taken on a rising edge where start is high and busy is
// low. Command 0 pushes operand_value; commands 1 to 4 pop the right and
// then the left operand and push their sum, difference, product or
// quotient (truncated toward zero); commands 5 to 7 leave the stack as it
// is. Each token gives exactly one result word, shown on top_value,
// stack_depth, underflow, overflow and divide_by_zero for the single cycle
// in which done is high; the receiver cannot stall, so it must capture the
// word in that cycle. A push or an unknown command keeps busy low and its
// result appears in the next cycle, so such tokens may arrive every cycle.
// Add, subtract and multiply hold busy through ST_OPER, which uses the left
// operand read from the stack memory, and ST_FINISH, which writes the result
// back. A divide by a nonzero divisor holds busy through the operand read in
// ST_OPER, the 32 steps of the radix-2 divider at one quotient bit per cycle
// and the taking of the quotient in ST_DIV, and the write-back in ST_FINISH.
// A divide by zero skips ST_DIV and the divider entirely. A pop from an
// empty stack gives all ones and sets underflow, a push onto a full stack
// is dropped and sets overflow, and a zero divisor pushes 0 and sets
// divide_by_zero. top_value reads 0 when the stack is empty. Stack memory
// needs no clearing pass: only entries below the depth are ever used.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_unit #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [31:0] operand_value,
  output logic        done,
  output logic [31:0] top_value,
  output logic [6:0]  stack_depth,
  output logic        underflow,
  output logic        overflow,
  output logic        divide_by_zero
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned PW = $clog2(STACK_DEPTH + 1);

  psev_pkg::state_t state;
  psev_pkg::state_t state_next;

  // Stack bookkeeping. The top entry is mirrored in a register so that an
  // operator needs only one memory read, for its left operand.
  logic [PW-1:0]   sp;
  logic [PW-1:0]   sp_after;
  logic [AW-1:0]   wr_idx;
  psev_pkg::word_t top_word;

  // Token latched at acceptance.
  psev_pkg::cmd_t  cmd_r;
  psev_pkg::word_t right_r;
  logic            have_left;
  psev_pkg::word_t res_r;

  logic under_r;
  logic over_r;
  logic dz_r;
  logic done_r;

  logic            accept;
  logic            sp_full;
  logic            sp_ge2;
  logic [PW-1:0]   sp_m2;
  psev_pkg::word_t left_w;
  psev_pkg::word_t product;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  psev_pkg::word_t ram_wdata;
  psev_pkg::word_t ram_rdata;

  logic            div_start;
  logic            div_done;
  psev_pkg::word_t div_quot;

  logic            res_load;
  psev_pkg::word_t res_next;
  logic            dz_set;

  logic [PW+6:0]   depth_ext;

  assign accept = start && !busy;
  assign busy = (state != psev_pkg::ST_IDLE);
  assign sp_full = (sp == PW'(STACK_DEPTH));
  assign sp_ge2 = (sp >= PW'(2));
  assign sp_m2 = sp - PW'(2);
  assign left_w = have_left ? ram_rdata : psev_pkg::EMPTY_POP_VALUE;
  assign product = left_w * right_r;

  psev_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (sp_m2[AW-1:0]),
    .rdata (ram_rdata)
  );

  psev_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (left_w),
    .divisor  (right_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psev_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state, memory write port, divider start, the operator
  // result and the divide-by-zero flag.
  always_comb begin
    state_next = state;
    ram_we = 1'b0;
    ram_waddr = sp[AW-1:0];
    ram_wdata = operand_value;
    div_start = 1'b0;
    res_load = 1'b0;
    res_next = '0;
    dz_set = 1'b0;
    case (state)
      psev_pkg::ST_IDLE: begin
        if (accept) begin
          if (command == psev_pkg::CMD_PUSH) begin
            ram_we = !sp_full;
          end else if (command inside {[psev_pkg::CMD_ADD:psev_pkg::CMD_DIV]}) begin
            state_next = psev_pkg::ST_OPER;
          end
        end
      end
      psev_pkg::ST_OPER: begin
        state_next = psev_pkg::ST_FINISH;
        res_load = 1'b1;
        case (cmd_r)
          psev_pkg::CMD_ADD: res_next = left_w + right_r;
          psev_pkg::CMD_SUB: res_next = left_w - right_r;
          psev_pkg::CMD_MUL: res_next = product;
          default: begin
            if (right_r == '0) begin
              dz_set = 1'b1;
            end else begin
              res_load = 1'b0;
              div_start = 1'b1;
              state_next = psev_pkg::ST_DIV;
            end
          end
        endcase
      end
      psev_pkg::ST_DIV: begin
        if (div_done) begin
          res_load = 1'b1;
          res_next = div_quot;
          state_next = psev_pkg::ST_FINISH;
        end
      end
      psev_pkg::ST_FINISH: begin
        ram_we = 1'b1;
        ram_waddr = wr_idx;
        ram_wdata = res_r;
        state_next = psev_pkg::ST_IDLE;
      end
      default: begin
        state_next = psev_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers: stack pointer, flags and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
      done_r <= 1'b0;
      under_r <= 1'b0;
      over_r <= 1'b0;
      dz_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (accept) begin
        under_r <= 1'b0;
        over_r <= 1'b0;
        dz_r <= 1'b0;
        case (command)
          psev_pkg::CMD_PUSH: begin
            done_r <= 1'b1;
            if (sp_full) begin
              over_r <= 1'b1;
            end else begin
              sp <= sp + PW'(1);
            end
          end
          psev_pkg::CMD_ADD, psev_pkg::CMD_SUB, psev_pkg::CMD_MUL,
          psev_pkg::CMD_DIV: begin
            under_r <= !sp_ge2;
          end
          default: begin
            done_r <= 1'b1;
          end
        endcase
      end
      if (dz_set) begin
        dz_r <= 1'b1;
      end
      if (state == psev_pkg::ST_FINISH) begin
        sp <= sp_after;
        done_r <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= command;
      right_r <= (sp != '0) ? top_word : psev_pkg::EMPTY_POP_VALUE;
      have_left <= sp_ge2;
      sp_after <= sp_ge2 ? (sp - PW'(1)) : PW'(1);
      wr_idx <= sp_ge2 ? sp_m2[AW-1:0] : '0;
      if (command == psev_pkg::CMD_PUSH && !sp_full) begin
        top_word <= operand_value;
      end
    end
    if (res_load) begin
      res_r <= res_next;
    end
    if (state == psev_pkg::ST_FINISH) begin
      top_word <= res_r;
    end
  end

  assign depth_ext = {7'd0, sp};

  assign done = done_r;
  assign top_value = (sp != '0) ? top_word : '0;
  assign stack_depth = depth_ext[6:0];
  assign underflow = under_r;
  assign overflow = over_r;
  assign divide_by_zero = dz_r;

endmodule

[design/psev_checker.sv]
// ----------------------------------------------------------------------------
// psev_checker: port-level checks for the postfix stack evaluator
// Watches the top-level ports over time; attached by the bind below.
// ----------------------------------------------------------------------------
module psev_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [2:0]  command,
  input logic        done,
  input logic [31:0] top_value,
  input logic [6:0]  stack_depth,
  input logic        underflow,
  input logic        overflow,
  input logic        divide_by_zero
);

  // A result word is only shown once the sequencer has let go of busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done raised while busy");

  // A push finishes without holding busy and reports in the next cycle.
  a_push_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == psev_pkg::CMD_PUSH) |=> (done && !busy))
    else $error("push did not report in the next cycle");

  // An operator holds busy for its memory read before any result is shown.
  a_oper_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (command == psev_pkg::CMD_ADD || command == psev_pkg::CMD_SUB
      || command == psev_pkg::CMD_MUL || command == psev_pkg::CMD_DIV))
    |=> (busy && !done))
    else $error("operator did not hold busy");

  // A zero divisor pushes 0, so the stack holds a zero on top.
  a_dz_result: assert property (@(posedge clk) disable iff (rst)
    (done && divide_by_zero) |-> (top_value == 32'd0 && stack_depth != 7'd0
      && !overflow))
    else $error("divide by zero result is wrong");

  // An operator underflows only on a stack with fewer than two entries, and
  // its result is then the only entry left.
  a_under_depth: assert property (@(posedge clk) disable iff (rst)
    (done && underflow) |-> (stack_depth == 7'd1 && !overflow))
    else $error("underflow result has the wrong depth");

endmodule

bind postfix_stack_evaluator_unit psev_checker u_psev_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .command        (command),
  .done           (done),
  .top_value      (top_value),
  .stack_depth    (stack_depth),
  .underflow      (underflow),
  .overflow       (overflow),
  .divide_by_zero (divide_by_zero)
);
